>>> rtl/core/rbei_pkg.sv
// Shared types and constants for the rigid body Euler integrator.
`timescale 1ns / 1ps
package rbei_pkg;

    localparam int unsigned FX_W   = 32;
    localparam int unsigned ID_W   = 16;
    localparam int unsigned DAMP_W = 17;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 3'd0,
        OP_DESTROY  = 3'd1,
        OP_ADDFORCE = 3'd2,
        OP_SETVEL   = 3'd3,
        OP_SETDAMP  = 3'd4,
        OP_READ     = 3'd5,
        OP_STEP     = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_MASS  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDAMP  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [ID_W-1:0]          body_id;
        logic signed [FX_W-1:0]   vec_x;
        logic signed [FX_W-1:0]   vec_y;
        logic signed [FX_W-1:0]   vec_z;
        logic signed [FX_W-1:0]   mass;
        logic [DAMP_W-1:0]        damping_rate;
        logic [DAMP_W-1:0]        delta_time;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic [ID_W-1:0]          result_id;
        logic signed [FX_W-1:0]   pos_x;
        logic signed [FX_W-1:0]   pos_y;
        logic signed [FX_W-1:0]   pos_z;
        logic signed [FX_W-1:0]   vel_x;
        logic signed [FX_W-1:0]   vel_y;
        logic signed [FX_W-1:0]   vel_z;
    } out_item_t;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic       scan_start;   // begin slot sweep
        logic       upd_start;    // begin op on found or free slot
        logic       fin_start;    // build result item
    } dp_cmd_t;

    typedef struct packed {
        logic       scan_done;
        logic       upd_done;
        logic       fin_done;
    } dp_stat_t;

    function automatic logic signed [FX_W-1:0] sat32(input logic signed [FX_W+1:0] x);
        logic signed [FX_W+1:0] mx;
        logic signed [FX_W+1:0] mn;
        begin
            mx = {3'b000, {(FX_W-1){1'b1}}};
            mn = {3'b111, {(FX_W-1){1'b0}}};
            if (x > mx)
                sat32 = {1'b0, {(FX_W-1){1'b1}}};
            else if (x < mn)
                sat32 = {1'b1, {(FX_W-1){1'b0}}};
            else
                sat32 = x[FX_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/rbei_ctrl.sv
// Operation sequencer for the integrator: scan, update, respond.
`timescale 1ns / 1ps
module rbei_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_fire,
    input  rbei_pkg::dp_stat_t stat,
    output rbei_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               out_valid
);
    import rbei_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_UPD  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.upd_start = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (stat.upd_done)
                begin
                    cmd.fin_start = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.fin_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_fire) |=> out_valid)
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_fire)
        else $error("item taken while busy");
`endif
endmodule

>>> rtl/core/rbei_dp.sv
// Body table, slot sweep, step arithmetic, divider and result register.
`timescale 1ns / 1ps
module rbei_dp #(
    parameter int unsigned MAX_BODIES = 64,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rbei_pkg::dp_cmd_t     cmd,
    output rbei_pkg::dp_stat_t    stat,
    input  rbei_pkg::in_item_t    in_item,
    input  logic                  in_fire,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_idx,
    input  logic [31:0]           cfg_data,
    output rbei_pkg::out_item_t   result
);
    import rbei_pkg::*;

    localparam int unsigned SW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int unsigned CW = $clog2(MAX_BODIES + 1);
    localparam logic [CW-1:0] LAST = CW'(MAX_BODIES - 1);
    localparam int unsigned PW = 64;

    typedef logic signed [FX_W-1:0] fx_t;
    typedef logic signed [FX_W+1:0] fxw_t;

    // Registers
    fx_t gx_reg, gy_reg, gz_reg, gnd_reg;
    logic [DAMP_W-1:0] idamp_reg;
    logic [ID_W-1:0] next_id_reg;
    logic [MAX_BODIES-1:0] valid_reg;
    in_item_t item_reg;

    // Table memories, one record per slot
    typedef struct packed {
        logic [ID_W-1:0] id;
        fx_t px, py, pz, vx, vy, vz, fx, fy, fz, m;
        logic [DAMP_W-1:0] d;
    } rec_t;
    rec_t mem [MAX_BODIES];

    // Sweep control
    logic [CW-1:0] idx_reg;
    logic scan_reg;
    logic [3:0] ph_reg;          // step pipeline phase per slot
    logic found_reg, free_ok_reg;
    logic [SW-1:0] hit_reg, free_reg;
    rec_t rd_reg, cur_reg;
    logic upd_reg;
    logic upd_wait_reg;          // wait for the target slot read
    logic [5:0] dcnt_reg;
    logic [1:0] dax_reg;
    logic fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg <= '0;
            gy_reg <= -32'sd642908;
            gz_reg <= '0;
            gnd_reg <= -32'sd327680;
            idamp_reg <= 17'd655;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_GRAV_X: gx_reg <= cfg_data;
                CFG_GRAV_Y: gy_reg <= cfg_data;
                CFG_GRAV_Z: gz_reg <= cfg_data;
                CFG_GROUND: gnd_reg <= cfg_data;
                CFG_IDAMP:  idamp_reg <= cfg_data[DAMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
        if (in_fire)
            item_reg <= in_item;

    op_t op;
    assign op = op_t'(item_reg.operation);
    logic [SW-1:0] idx_s;
    assign idx_s = idx_reg[SW-1:0];

    // Step arithmetic: per-slot phases share one multiplier, at most one multiply per phase.
    fx_t fac_reg;
    logic [1:0] ax_reg;
    fx_t mul_a;
    logic signed [FX_W:0] mul_b;
    logic signed [PW-1:0] mul_p;
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    function automatic fx_t fl_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        begin
            s = p >>> FRAC_BITS;
            if (s > 64'sd2147483647)
                fl_sat = 32'sh7fffffff;
            else if (s < -64'sd2147483648)
                fl_sat = 32'sh80000000;
            else
                fl_sat = s[FX_W-1:0];
        end
    endfunction

    function automatic fx_t vsel(input rec_t r, input logic [1:0] a);
        case (a)
            2'd0: vsel = r.vx;
            2'd1: vsel = r.vy;
            default: vsel = r.vz;
        endcase
    endfunction
    function automatic fx_t psel(input rec_t r, input logic [1:0] a);
        case (a)
            2'd0: psel = r.px;
            2'd1: psel = r.py;
            default: psel = r.pz;
        endcase
    endfunction
    function automatic fx_t fsel(input rec_t r, input logic [1:0] a);
        case (a)
            2'd0: fsel = r.fx;
            2'd1: fsel = r.fy;
            default: fsel = r.fz;
        endcase
    endfunction
    fx_t gsel;
    always_comb
    begin
        case (ax_reg)
            2'd0: gsel = gx_reg;
            2'd1: gsel = gy_reg;
            default: gsel = gz_reg;
        endcase
    end
    fx_t dtf;
    assign dtf = FX_W'(item_reg.delta_time);

    // phases: 0 read, 1 damp-factor, 2..4 damp v, 5..7 accel, 8..10 pos, 11 write
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (ph_reg == 4'd1)
        begin
            mul_a = FX_W'(rd_reg.d);
            mul_b = (FX_W+1)'(dtf);
        end
        else if (ph_reg >= 4'd2 && ph_reg <= 4'd4)
        begin
            mul_a = vsel(cur_reg, ax_reg);
            mul_b = (FX_W+1)'(fac_reg);
        end
        else if (ph_reg >= 4'd5 && ph_reg <= 4'd7)
        begin
            mul_a = sat32(fxw_t'(gsel) + fxw_t'(fsel(cur_reg, ax_reg)));
            mul_b = (FX_W+1)'(dtf);
        end
        else if (ph_reg >= 4'd8 && ph_reg <= 4'd10)
        begin
            mul_a = vsel(cur_reg, ax_reg);
            mul_b = (FX_W+1)'(dtf);
        end
    end

    // Divider for add force: restoring, one quotient bit per cycle.
    logic [PW-1:0] drem_reg, dq_reg;
    logic dneg_reg;
    logic dbusy_reg;

    logic [PW-1:0] rem_sh;
    assign rem_sh = {drem_reg[PW-2:0], dq_reg[PW-1]};

    fx_t rd_acc_x, rd_acc_y, rd_acc_z;
    fx_t qnext;
    always_comb
    begin
        logic [PW-1:0] qn;
        logic signed [PW-1:0] qs;
        qn = (rem_sh >= PW'(rd_reg.m)) ? {dq_reg[PW-2:0], 1'b1} : {dq_reg[PW-2:0], 1'b0};
        qs = dneg_reg ? -$signed(qn) : $signed(qn);
        if (qs > 64'sd2147483647)
            qnext = 32'sh7fffffff;
        else if (qs < -64'sd2147483648)
            qnext = 32'sh80000000;
        else
            qnext = qs[FX_W-1:0];
    end

    fx_t vec_sel;
    always_comb
    begin
        case (dax_reg)
            2'd0: vec_sel = item_reg.vec_x;
            2'd1: vec_sel = item_reg.vec_y;
            default: vec_sel = item_reg.vec_z;
        endcase
    end

    rec_t wr_rec;
    logic wr_en;
    logic [SW-1:0] wr_addr;

    always_comb
    begin
        wr_rec = cur_reg;
        wr_en = 1'b0;
        wr_addr = hit_reg;
        if (scan_reg && op == OP_STEP && ph_reg == 4'd11)
        begin
            wr_en = 1'b1;
            wr_addr = idx_s;
            if (cur_reg.py < gnd_reg)
            begin
                wr_rec.py = gnd_reg;
                wr_rec.vy = '0;
            end
            wr_rec.fx = '0;
            wr_rec.fy = '0;
            wr_rec.fz = '0;
        end
        else if (upd_reg)
        begin
            wr_addr = (op == OP_CREATE) ? free_reg : hit_reg;
        end
    end

    logic mass_ok;
    assign mass_ok = !item_reg.mass[FX_W-1] && (item_reg.mass != '0);

    // Update phase: rd_reg holds the target slot once the wait cycle is over.
    logic upd_go, div_run, upd_last;
    assign upd_go   = upd_reg && !upd_wait_reg;
    assign div_run  = op == OP_ADDFORCE && found_reg && rd_reg.m[FX_W-1] == 1'b0 &&
                      rd_reg.m != '0 && (dbusy_reg || dax_reg != 2'd3);
    assign upd_last = upd_go && !div_run;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_rec;
        else if (upd_last)
        begin
            if (op == OP_CREATE && mass_ok && free_ok_reg)
            begin
                mem[free_reg] <= '{id: next_id_reg, px: item_reg.vec_x,
                    py: item_reg.vec_y, pz: item_reg.vec_z, vx: '0, vy: '0, vz: '0,
                    fx: '0, fy: '0, fz: '0, m: item_reg.mass, d: idamp_reg};
            end
            else if (found_reg && op == OP_SETVEL)
            begin
                mem[hit_reg] <= '{id: rd_reg.id, px: rd_reg.px, py: rd_reg.py,
                    pz: rd_reg.pz, vx: item_reg.vec_x, vy: item_reg.vec_y,
                    vz: item_reg.vec_z, fx: rd_reg.fx, fy: rd_reg.fy, fz: rd_reg.fz,
                    m: rd_reg.m, d: rd_reg.d};
            end
            else if (found_reg && op == OP_SETDAMP)
            begin
                mem[hit_reg] <= '{id: rd_reg.id, px: rd_reg.px, py: rd_reg.py,
                    pz: rd_reg.pz, vx: rd_reg.vx, vy: rd_reg.vy, vz: rd_reg.vz,
                    fx: rd_reg.fx, fy: rd_reg.fy, fz: rd_reg.fz, m: rd_reg.m,
                    d: item_reg.damping_rate};
            end
            else if (found_reg && op == OP_ADDFORCE)
            begin
                mem[hit_reg] <= '{id: rd_reg.id, px: rd_reg.px, py: rd_reg.py,
                    pz: rd_reg.pz, vx: rd_reg.vx, vy: rd_reg.vy, vz: rd_reg.vz,
                    fx: rd_acc_x, fy: rd_acc_y, fz: rd_acc_z, m: rd_reg.m,
                    d: rd_reg.d};
            end
        end
        rd_reg <= mem[idx_s];
    end

    // Sweep: ID search (and step update) one slot at a time.
    // Lookup uses a second pass after the step so search sees new state.
    logic pass2_reg;
    logic [1:0] rdw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= 1'b0;
            idx_reg <= '0;
            ph_reg <= '0;
            found_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            pass2_reg <= 1'b0;
            stat <= '0;
            upd_reg <= 1'b0;
            upd_wait_reg <= 1'b0;
            fin_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            dcnt_reg <= '0;
            dax_reg <= '0;
            valid_reg <= '0;
            next_id_reg <= 16'd1;
            rdw_reg <= '0;
            hit_reg <= '0;
            free_reg <= '0;
        end
        else
        begin
            stat <= '0;
            if (cmd.scan_start)
            begin
                scan_reg <= 1'b1;
                idx_reg <= '0;
                ph_reg <= '0;
                found_reg <= 1'b0;
                free_ok_reg <= 1'b0;
                pass2_reg <= (op_t'(in_item.operation) != OP_STEP);
                rdw_reg <= '0;
            end
            else if (scan_reg && !pass2_reg)
            begin
                // step pass
                if (!valid_reg[idx_s])
                begin
                    if (idx_reg == LAST)
                    begin
                        pass2_reg <= 1'b1;
                        idx_reg <= '0;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                    ph_reg <= '0;
                end
                else
                begin
                    if (ph_reg == 4'd11)
                    begin
                        ph_reg <= '0;
                        if (idx_reg == LAST)
                        begin
                            pass2_reg <= 1'b1;
                            idx_reg <= '0;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                    else
                        ph_reg <= ph_reg + 1'b1;
                end
            end
            else if (scan_reg)
            begin
                // lookup pass: rdw_reg waits for the registered slot read
                if (rdw_reg == 2'd0)
                    rdw_reg <= 2'd1;
                else
                begin
                    rdw_reg <= 2'd0;
                    if (!valid_reg[idx_s] && !free_ok_reg)
                    begin
                        free_ok_reg <= 1'b1;
                        free_reg <= idx_s;
                    end
                    if (valid_reg[idx_s] && rd_reg.id == item_reg.body_id &&
                        item_reg.body_id != '0 && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_reg <= idx_s;
                    end
                    if (idx_reg == LAST)
                    begin
                        scan_reg <= 1'b0;
                        stat.scan_done <= 1'b1;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
            end

            if (cmd.upd_start)
            begin
                upd_reg <= 1'b1;
                upd_wait_reg <= 1'b1;
                dax_reg <= '0;
                dcnt_reg <= '0;
                idx_reg <= (op == OP_CREATE) ? CW'(free_reg) : CW'(hit_reg);
            end
            else if (upd_reg && upd_wait_reg)
                upd_wait_reg <= 1'b0;
            else if (upd_reg)
            begin
                if (div_run)
                begin
                    if (!dbusy_reg)
                    begin
                        dbusy_reg <= 1'b1;
                        dcnt_reg <= 6'd63;
                    end
                    else if (dcnt_reg == 6'd0)
                    begin
                        dbusy_reg <= 1'b0;
                        dax_reg <= dax_reg + 1'b1;
                    end
                    else
                        dcnt_reg <= dcnt_reg - 1'b1;
                end
                else
                begin
                    upd_reg <= 1'b0;
                    stat.upd_done <= 1'b1;
                    if (op == OP_CREATE && mass_ok && free_ok_reg)
                    begin
                        valid_reg[free_reg] <= 1'b1;
                        next_id_reg <= (next_id_reg == 16'hffff) ? 16'd1
                                                                  : next_id_reg + 1'b1;
                    end
                end
            end

            if (cmd.fin_start)
                fin_reg <= 1'b1;
            else if (fin_reg)
            begin
                fin_reg <= 1'b0;
                stat.fin_done <= 1'b1;
                if (op == OP_DESTROY && found_reg)
                    valid_reg[hit_reg] <= 1'b0;
            end
        end
    end

    // Step phase datapath and divider registers
    always_ff @(posedge clk)
    begin
        if (scan_reg && !pass2_reg && valid_reg[idx_s])
        begin
            case (ph_reg)
                4'd0: ax_reg <= '0;
                4'd1:
                begin
                    cur_reg <= rd_reg;
                    begin
                        logic signed [PW-1:0] f;
                        f = (64'sd1 <<< FRAC_BITS) - (mul_p >>> FRAC_BITS);
                        fac_reg <= (f < 0) ? '0 : f[FX_W-1:0];
                    end
                end
                4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10:
                begin
                    case (ax_reg)
                        2'd0:
                        begin
                            if (ph_reg <= 4'd4) cur_reg.vx <= fl_sat(mul_p);
                            else if (ph_reg <= 4'd7)
                                cur_reg.vx <= sat32(fxw_t'(cur_reg.vx) + fxw_t'(fl_sat(mul_p)));
                            else
                                cur_reg.px <= sat32(fxw_t'(cur_reg.px) + fxw_t'(fl_sat(mul_p)));
                        end
                        2'd1:
                        begin
                            if (ph_reg <= 4'd4) cur_reg.vy <= fl_sat(mul_p);
                            else if (ph_reg <= 4'd7)
                                cur_reg.vy <= sat32(fxw_t'(cur_reg.vy) + fxw_t'(fl_sat(mul_p)));
                            else
                                cur_reg.py <= sat32(fxw_t'(cur_reg.py) + fxw_t'(fl_sat(mul_p)));
                        end
                        default:
                        begin
                            if (ph_reg <= 4'd4) cur_reg.vz <= fl_sat(mul_p);
                            else if (ph_reg <= 4'd7)
                                cur_reg.vz <= sat32(fxw_t'(cur_reg.vz) + fxw_t'(fl_sat(mul_p)));
                            else
                                cur_reg.pz <= sat32(fxw_t'(cur_reg.pz) + fxw_t'(fl_sat(mul_p)));
                        end
                    endcase
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 1'b1;
                end
                default: ;
            endcase
        end

        if (upd_go && op == OP_ADDFORCE)
        begin
            if (!dbusy_reg && dax_reg != 2'd3)
            begin
                dneg_reg <= vec_sel[FX_W-1];
                dq_reg <= (vec_sel[FX_W-1] ? PW'(-(PW'(vec_sel))) : PW'(vec_sel)) << FRAC_BITS;
                drem_reg <= '0;
            end
            else if (dbusy_reg)
            begin
                if (rem_sh >= PW'(rd_reg.m))
                begin
                    drem_reg <= rem_sh - PW'(rd_reg.m);
                    dq_reg <= {dq_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= rem_sh;
                    dq_reg <= {dq_reg[PW-2:0], 1'b0};
                end
                if (dcnt_reg == 6'd0)
                begin
                    case (dax_reg)
                        2'd0: rd_acc_x <= sat32(fxw_t'(rd_acc_x) + fxw_t'(qnext));
                        2'd1: rd_acc_y <= sat32(fxw_t'(rd_acc_y) + fxw_t'(qnext));
                        default: rd_acc_z <= sat32(fxw_t'(rd_acc_z) + fxw_t'(qnext));
                    endcase
                end
            end
        end
        if (upd_go && op == OP_ADDFORCE && !dbusy_reg && dax_reg == 2'd0)
        begin
            rd_acc_x <= rd_reg.fx;
            rd_acc_y <= rd_reg.fy;
            rd_acc_z <= rd_reg.fz;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (fin_reg)
        begin
            result <= '0;
            if (op == OP_CREATE)
            begin
                if (!mass_ok)
                    result.status <= ST_BAD_MASS;
                else if (!free_ok_reg)
                    result.status <= ST_FULL;
                else
                begin
                    result.status <= ST_OK;
                    result.result_id <= rd_reg.id;
                    result.pos_x <= rd_reg.px;
                    result.pos_y <= rd_reg.py;
                    result.pos_z <= rd_reg.pz;
                end
            end
            else if (!found_reg)
                result.status <= ST_NOT_FOUND;
            else
            begin
                result.status <= ST_OK;
                result.result_id <= rd_reg.id;
                result.pos_x <= rd_reg.px;
                result.pos_y <= rd_reg.py;
                result.pos_z <= rd_reg.pz;
                result.vel_x <= (op == OP_SETVEL) ? item_reg.vec_x : rd_reg.vx;
                result.vel_y <= (op == OP_SETVEL) ? item_reg.vec_y : rd_reg.vy;
                result.vel_z <= (op == OP_SETVEL) ? item_reg.vec_z : rd_reg.vz;
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST)
        else $error("slot index out of range");
    a_nextid_nz: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("next id zero");
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({scan_reg, upd_reg, fin_reg}))
        else $error("datapath phases overlap");
`endif
endmodule

>>> rtl/core/rigid_body_euler_integrator.sv
// Top level of the rigid body Euler integrator.
`timescale 1ns / 1ps
// A step sweeps all MAX_BODIES slots, running the step phases on each live
// body and passing over empty slots, then sweeps all slots again for the
// lookup; other operations take only the lookup sweep, and add force adds a
// bit-serial division per axis. One item is in flight at a time.
// Reset: table cleared (valid bits), next id 1, config registers to their defaults.
module rigid_body_euler_integrator #(
    parameter int unsigned MAX_BODIES = 64,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rbei_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rbei_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import rbei_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic busy;
    logic in_fire, out_fire;

    // Only accept while idle; the controller holds busy until the item leaves.
    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;
    assign out_fire = out_valid && !out_stall;

    rbei_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid)
    );

    rbei_dp #(
        .MAX_BODIES (MAX_BODIES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_item  (in_data),
        .in_fire  (in_fire),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .result   (out_data)
    );
endmodule
